/* src/sqln_pkg.sv */
// shared types and constants for the sql query literal normalizer
`default_nettype none

package sqln_pkg;

    // fixed field widths
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 16;
    // most characters one input byte can produce
    localparam int MAX_CHARS = 3;

    // characters the lexer and the back end write or look for
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CH_QMARK = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

    // lexer mode
    typedef enum logic [5:0] {
        MODE_NORM = 6'b000001,
        MODE_STR  = 6'b000010,
        MODE_STRQ = 6'b000100,
        MODE_NUM  = 6'b001000,
        MODE_FRAC = 6'b010000,
        MODE_FULL = 6'b100000
    } t_mode;

    // results of one input byte: up to three characters, then an optional end item
    typedef struct packed {
        logic [1:0]                        n_chars;
        logic [MAX_CHARS-1:0][BYTE_W-1:0]  chars;
        logic                              has_end;
        logic [LEN_W-1:0]                  len;
    } t_packet;

endpackage

`default_nettype wire

/* src/sql_query_literal_normalizer.sv */
// top level of the sql query literal normalizer
//
// Normalizes a SQL query streamed in one byte per transfer on the input
// channel (i_in_valid / o_in_ready, i_in_byte, i_last_byte). String and
// number literals become '?', whitespace runs collapse to one space, letters
// are lowered, and output is capped at the configured length. Each result
// item leaves on the output channel (o_out_valid / i_out_ready): characters
// with o_is_char set, and after the last byte an end item carrying the
// number of characters written.
// The capacity register is written through i_cfg_valid / o_cfg_ready /
// i_cfg_data, always ready; the user must write it only while the block
// is idle; the block itself does not enforce this. Throughput: one input
// byte per cycle while the packet queue has room; one result item per
// cycle from the output register while i_out_ready is high. A byte yields
// zero to four items, so a burst of multi-item bytes fills the QUEUE_DEPTH
// packet queue and then holds o_in_ready low. Reset (synchronous, active
// low) restores normal mode, drops queued items and sets the capacity to
// all ones. A stalled receiver holds the output item steady and backs up
// into the queue, then into the input channel.
`default_nettype none

module sql_query_literal_normalizer #(
    parameter int LEN_BITS    = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [sqln_pkg::LEN_W-1:0]  i_cfg_data,
    // input bytes
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [sqln_pkg::BYTE_W-1:0] i_in_byte,
    input  wire logic                        i_last_byte,
    // result items
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [sqln_pkg::BYTE_W-1:0]      o_out_char,
    output logic                             o_is_char,
    output logic                             o_end_of_query,
    output logic [sqln_pkg::LEN_W-1:0]       o_written_len
);

    logic              w_take;
    logic              w_push;
    logic              w_full;
    logic              w_pop;
    logic              w_nonempty;
    sqln_pkg::t_packet w_packet;
    sqln_pkg::t_packet w_head;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !w_full;
    assign w_take      = i_in_valid && !w_full;

    // lexer
    sqln_front #(
        .LEN_BITS (LEN_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_take      (w_take),
        .i_byte      (i_in_byte),
        .i_last      (i_last_byte),
        .o_push      (w_push),
        .o_packet    (w_packet)
    );

    // packet queue
    sqln_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_packet   (w_packet),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_nonempty (w_nonempty)
    );

    // output serializer
    sqln_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_nonempty     (w_nonempty),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_char     (o_out_char),
        .o_is_char      (o_is_char),
        .o_end_of_query (o_end_of_query),
        .o_written_len  (o_written_len)
    );

endmodule

`default_nettype wire

/* src/sqln_front.sv */
// front end: byte lexer, capacity tracking and per-byte result packets
`default_nettype none

module sqln_front #(
    parameter int LEN_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration write
    input  wire logic                        i_cfg_valid,
    input  wire logic [sqln_pkg::LEN_W-1:0]  i_cfg_data,
    // input byte, already qualified by the transfer
    input  wire logic                        i_take,
    input  wire logic [sqln_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                        i_last,
    // packet into the queue
    output logic                             o_push,
    output sqln_pkg::t_packet                o_packet
);

    localparam int CNT_W = (LEN_BITS < sqln_pkg::LEN_W) ? LEN_BITS : sqln_pkg::LEN_W;

    typedef struct packed {
        sqln_pkg::t_mode    mode;
        logic               pend;
        logic               after;
        logic [CNT_W-1:0]   cnt;
    } t_lex;

    typedef struct packed {
        t_lex               lex;
        sqln_pkg::t_packet  pkt;
    } t_work;

    t_lex             r_lex;
    t_lex             n_lex;
    logic [CNT_W-1:0] r_max;
    t_work            w_step;

    // write one character, with a deferred space ahead of it when it fits
    function automatic t_work f_emit(t_work w, logic [sqln_pkg::BYTE_W-1:0] c,
                                     logic [CNT_W-1:0] max);
        t_work r;
        r = w;
        if (w.lex.pend) begin
            if (({1'b0, w.lex.cnt} + (CNT_W+1)'(1)) < {1'b0, max}) begin
                r.pkt.chars[r.pkt.n_chars] = sqln_pkg::CH_SPACE;
                r.pkt.chars[r.pkt.n_chars + 2'd1] = c;
                r.pkt.n_chars = r.pkt.n_chars + 2'd2;
                r.lex.cnt = w.lex.cnt + CNT_W'(2);
            end else if (w.lex.cnt < max) begin
                r.lex.mode = sqln_pkg::MODE_FULL;
            end
            r.lex.pend = 1'b0;
        end else if (w.lex.cnt < max) begin
            r.pkt.chars[r.pkt.n_chars] = c;
            r.pkt.n_chars = r.pkt.n_chars + 2'd1;
            r.lex.cnt = w.lex.cnt + CNT_W'(1);
        end
        r.lex.after = 1'b0;
        return r;
    endfunction

    // normal text handling of one byte
    function automatic t_work f_norm(t_work w, logic [sqln_pkg::BYTE_W-1:0] b,
                                     logic [CNT_W-1:0] max);
        t_work r;
        r = w;
        r.lex.mode = sqln_pkg::MODE_NORM;
        if (b == sqln_pkg::CH_QUOTE) begin
            r.lex.mode = sqln_pkg::MODE_STR;
        end else if (b inside {["0":"9"]}) begin
            r.lex.mode = sqln_pkg::MODE_NUM;
        end else if (b == sqln_pkg::CH_SPACE || b inside {[8'd9:8'd13]}) begin
            if (!w.lex.after) begin
                r.lex.pend  = 1'b1;
                r.lex.after = 1'b1;
            end
        end else if (b inside {["A":"Z"]}) begin
            r = f_emit(r, b + 8'd32, max);
        end else begin
            r = f_emit(r, b, max);
        end
        return r;
    endfunction

    // close a string or number literal with a '?'; the mode shows whether the byte goes on as normal text
    function automatic t_work f_close(t_work w, logic [CNT_W-1:0] max);
        t_work r;
        r = w;
        r.lex.mode = sqln_pkg::MODE_NORM;
        r = f_emit(r, sqln_pkg::CH_QMARK, max);
        return r;
    endfunction

    // all results and the next state for one byte
    function automatic t_work f_step(t_lex s, logic [sqln_pkg::BYTE_W-1:0] b, logic last,
                                     logic [CNT_W-1:0] max);
        t_work r;
        logic  again;
        logic  is_digit;
        r.lex = s;
        r.pkt = '0;
        again = 1'b0;
        is_digit = (b inside {["0":"9"]});
        case (s.mode)
            sqln_pkg::MODE_FULL: begin
                again = 1'b0;
            end
            sqln_pkg::MODE_STR: begin
                if (b == sqln_pkg::CH_QUOTE) r.lex.mode = sqln_pkg::MODE_STRQ;
            end
            sqln_pkg::MODE_STRQ: begin
                if (b == sqln_pkg::CH_QUOTE) begin
                    r.lex.mode = sqln_pkg::MODE_STR;
                end else begin
                    r = f_close(r, max);
                    again = (r.lex.mode != sqln_pkg::MODE_FULL);
                end
            end
            sqln_pkg::MODE_NUM: begin
                if (b == sqln_pkg::CH_DOT) begin
                    r.lex.mode = sqln_pkg::MODE_FRAC;
                end else if (!is_digit) begin
                    r = f_close(r, max);
                    again = (r.lex.mode != sqln_pkg::MODE_FULL);
                end
            end
            sqln_pkg::MODE_FRAC: begin
                if (!is_digit) begin
                    r = f_close(r, max);
                    again = (r.lex.mode != sqln_pkg::MODE_FULL);
                end
            end
            default: begin
                again = 1'b1;
            end
        endcase
        if (again) r = f_norm(r, b, max);
        // end of query: close a pending literal (an open string is dropped), report the length, restart
        if (last) begin
            if (r.lex.mode == sqln_pkg::MODE_NUM || r.lex.mode == sqln_pkg::MODE_FRAC ||
                r.lex.mode == sqln_pkg::MODE_STRQ) begin
                r = f_close(r, max);
            end
            r.pkt.has_end = 1'b1;
            r.pkt.len     = sqln_pkg::LEN_W'(r.lex.cnt);
            r.lex.mode    = sqln_pkg::MODE_NORM;
            r.lex.pend    = 1'b0;
            r.lex.after   = 1'b1;
            r.lex.cnt     = '0;
        end
        return r;
    endfunction

    // classify the byte on the input port
    always_comb begin
        w_step = f_step(r_lex, i_byte, i_last, r_max);
        n_lex  = w_step.lex;
    end

    assign o_packet = w_step.pkt;
    assign o_push   = i_take && (w_step.pkt.n_chars != 2'd0 || w_step.pkt.has_end);

    // lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lex.mode  <= sqln_pkg::MODE_NORM;
            r_lex.pend  <= 1'b0;
            r_lex.after <= 1'b1;
            r_lex.cnt   <= '0;
        end else if (i_take) begin
            r_lex <= n_lex;
        end
    end

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '1;
        end else if (i_cfg_valid) begin
            r_max <= i_cfg_data[CNT_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* src/sqln_queue.sv */
// short packet queue between the front end and the output serializer
`default_nettype none

module sqln_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire sqln_pkg::t_packet  i_packet,
    output logic                    o_full,
    input  wire logic               i_pop,
    output sqln_pkg::t_packet       o_head,
    output logic                    o_nonempty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sqln_pkg::t_packet           r_mem [DEPTH];
    logic [PTR_W-1:0]            r_wr;
    logic [PTR_W-1:0]            r_rd;
    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) n_count = r_count + CNT_W'(1);
        if (!i_push && i_pop) n_count = r_count - CNT_W'(1);
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            if (i_pop)  r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_packet;
    end

endmodule

`default_nettype wire

/* src/sqln_back.sv */
// back end: serializes queued packets into result items through an output register
`default_nettype none

module sqln_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire sqln_pkg::t_packet           i_head,
    input  wire logic                        i_nonempty,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [sqln_pkg::BYTE_W-1:0]      o_out_char,
    output logic                             o_is_char,
    output logic                             o_end_of_query,
    output logic [sqln_pkg::LEN_W-1:0]       o_written_len
);

    logic [1:0]                  r_idx;
    logic                        r_valid;
    logic [sqln_pkg::BYTE_W-1:0] r_char;
    logic                        r_is_char;
    logic [sqln_pkg::LEN_W-1:0]  r_len;
    logic [2:0]                  w_total;
    logic                        w_item_is_char;
    logic                        w_last_item;
    logic                        w_load;

    // item selection within the head packet
    assign w_total        = {1'b0, i_head.n_chars} + {2'b00, i_head.has_end};
    assign w_item_is_char = ({1'b0, r_idx} < {1'b0, i_head.n_chars});
    assign w_last_item    = ({1'b0, r_idx} == (w_total - 3'd1));
    assign w_load         = i_nonempty && (!r_valid || i_out_ready);
    assign o_pop          = w_load && w_last_item;

    // item index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (w_load) begin
            r_idx <= w_last_item ? 2'd0 : r_idx + 2'd1;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_is_char <= w_item_is_char;
            r_char    <= w_item_is_char ? i_head.chars[r_idx] : sqln_pkg::CH_NUL;
            r_len     <= w_item_is_char ? '0 : i_head.len;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_out_char     = r_char;
    assign o_is_char      = r_is_char;
    assign o_end_of_query = !r_is_char;
    assign o_written_len  = r_len;

endmodule

`default_nettype wire

/* src/sqln_checker.sv */
// port-level checker for the sql query literal normalizer, bound to the top level
`default_nettype none

module sqln_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [sqln_pkg::BYTE_W-1:0] o_out_char,
    input wire logic                        o_is_char,
    input wire logic                        o_end_of_query,
    input wire logic [sqln_pkg::LEN_W-1:0]  o_written_len
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_char) &&
        $stable(o_is_char) && $stable(o_written_len))
        else $error("result item changed while stalled");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // item kind flags are exclusive and unused fields are zero
    a_item_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_char != o_end_of_query) &&
        (o_is_char ? (o_written_len == '0) : (o_out_char == '0)))
        else $error("inconsistent result item fields");

    // letters always leave in lower case
    a_lower_case: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_char |-> !(o_out_char >= 8'h41 && o_out_char <= 8'h5A))
        else $error("upper case letter in output");

endmodule

bind sql_query_literal_normalizer sqln_checker u_sqln_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_out_char     (o_out_char),
    .o_is_char      (o_is_char),
    .o_end_of_query (o_end_of_query),
    .o_written_len  (o_written_len)
);

`default_nettype wire

/* tb/sv/sqln_output_checker.sv */
// output checker for the sql query literal normalizer: predicts each result item and compares
`timescale 1ns / 1ps

module sqln_output_checker
    import sqln_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    input  wire logic              i_cfg_ready,
    input  wire logic [LEN_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_ready,
    input  wire logic [BYTE_W-1:0] i_in_byte,
    input  wire logic              i_last_byte,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_ready,
    input  wire logic [BYTE_W-1:0] i_out_char,
    input  wire logic              i_is_char,
    input  wire logic              i_end_of_query,
    input  wire logic [LEN_W-1:0]  i_written_len,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              is_char;
        logic              eoq;
        logic [LEN_W-1:0]  len;
    } t_norm_item;

    t_norm_item expected_items[$];
    int         fail_total;

    // predicted lexer state and capacity
    t_mode      norm_mode;
    bit         space_held;
    bit         at_word_gap;
    int         written_count;
    int         cap_len;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fail_total   = 0;
    end

    function automatic void clear_query();
        norm_mode     = MODE_NORM;
        space_held    = 1'b0;
        at_word_gap   = 1'b1;
        written_count = 0;
    endfunction

    function automatic void queue_item(logic [BYTE_W-1:0] c, logic is_c, logic eoq,
                                       logic [LEN_W-1:0] len);
        t_norm_item it;
        it.ch      = c;
        it.is_char = is_c;
        it.eoq     = eoq;
        it.len     = len;
        expected_items.push_back(it);
    endfunction

    // a held space goes out only together with the character after it
    function automatic void put_char(logic [BYTE_W-1:0] c);
        if (space_held) begin
            if (written_count + 1 < cap_len) begin
                queue_item(CH_SPACE, 1'b1, 1'b0, '0);
                queue_item(c, 1'b1, 1'b0, '0);
                written_count += 2;
            end else if (written_count < cap_len) begin
                norm_mode = MODE_FULL;
            end
            space_held = 1'b0;
        end else if (written_count < cap_len) begin
            queue_item(c, 1'b1, 1'b0, '0);
            written_count += 1;
        end
        at_word_gap = 1'b0;
    endfunction

    // closes a literal; returns 1 when the byte still has to be handled as text
    function automatic bit finish_literal();
        norm_mode = MODE_NORM;
        put_char(CH_QMARK);
        return norm_mode != MODE_FULL;
    endfunction

    function automatic bit is_digit(logic [BYTE_W-1:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic void consume_byte(logic [BYTE_W-1:0] b, logic last);
        bit again;
        again = 1'b1;
        while (again && norm_mode != MODE_FULL) begin
            again = 1'b0;
            case (norm_mode)
                MODE_STR: begin
                    if (b == CH_QUOTE) norm_mode = MODE_STRQ;
                end
                MODE_STRQ: begin
                    if (b == CH_QUOTE) norm_mode = MODE_STR;
                    else again = finish_literal();
                end
                MODE_NUM: begin
                    if (b == CH_DOT) norm_mode = MODE_FRAC;
                    else if (!is_digit(b)) again = finish_literal();
                end
                MODE_FRAC: begin
                    if (!is_digit(b)) again = finish_literal();
                end
                default: begin
                    norm_mode = MODE_NORM;
                    if (b == CH_QUOTE) begin
                        norm_mode = MODE_STR;
                    end else if (is_digit(b)) begin
                        norm_mode = MODE_NUM;
                    end else if (b == CH_SPACE || (b >= 8'd9 && b <= 8'd13)) begin
                        if (!at_word_gap) begin
                            space_held  = 1'b1;
                            at_word_gap = 1'b1;
                        end
                    end else begin
                        put_char((b >= "A" && b <= "Z") ? b + 8'd32 : b);
                    end
                end
            endcase
        end
        // end of query: a pending literal closes, an open string is dropped
        if (last) begin
            if (norm_mode == MODE_NUM || norm_mode == MODE_FRAC || norm_mode == MODE_STRQ) begin
                norm_mode = MODE_NORM;
                put_char(CH_QMARK);
            end
            queue_item(CH_NUL, 1'b0, 1'b1, written_count[LEN_W-1:0]);
            clear_query();
        end
    endfunction

    function automatic void report_field(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_norm_item want;
        if (!i_rst_n) begin
            clear_query();
            cap_len = 65535;
            expected_items.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) cap_len = i_cfg_data;

            // compare each output transfer with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (expected_items.size() == 0) begin
                    $error("unexpected result: out_char 0x%0h is_char %0d end_of_query %0d",
                           i_out_char, i_is_char, i_end_of_query);
                    fail_total++;
                end else begin
                    want = expected_items.pop_front();
                    report_field("out_char", want.ch, i_out_char);
                    report_field("is_char", want.is_char, i_is_char);
                    report_field("end_of_query", want.eoq, i_end_of_query);
                    report_field("written_len", want.len, i_written_len);
                end
            end

            if (i_in_valid && i_in_ready) consume_byte(i_in_byte, i_last_byte);
        end
        o_pending    <= expected_items.size();
        o_fail_count <= fail_total;
    end

endmodule

/* tb/sv/tb.sv */
// testbench top for the sql query literal normalizer: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb;
    import sqln_pkg::*;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [LEN_W-1:0]  cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic [BYTE_W-1:0] in_byte   = '0;
    logic              last_byte = 1'b0;
    logic              out_ready = 1'b0;
    logic              cfg_ready;
    logic              in_ready;
    logic              out_valid;
    logic [BYTE_W-1:0] out_char;
    logic              is_char;
    logic              end_of_query;
    logic [LEN_W-1:0]  written_len;
    int                fail_count;
    int                pending;

    // no gaps and no stalls while set
    bit                calm = 1'b0;
    logic [BYTE_W-1:0] query_buf[$];
    int                bytes_sent;

    always #1 clk = ~clk;

    sql_query_literal_normalizer i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_in_byte      (in_byte),
        .i_last_byte    (last_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_out_char     (out_char),
        .o_is_char      (is_char),
        .o_end_of_query (end_of_query),
        .o_written_len  (written_len)
    );

    sqln_output_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_byte      (in_byte),
        .i_last_byte    (last_byte),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_char     (out_char),
        .i_is_char      (is_char),
        .i_end_of_query (end_of_query),
        .i_written_len  (written_len),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // receiver stalls: mostly short, a few long
    always @(posedge clk) begin
        int stall_left;
        int roll;
        roll = $urandom_range(0, 99);
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (!calm && roll < 20) begin
            stall_left = (roll < 3) ? $urandom_range(8, 30) : $urandom_range(0, 2);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one byte transfer, valid held until accepted
    task automatic send_byte(logic [BYTE_W-1:0] b, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_byte   <= b;
        last_byte <= last;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_query();
        foreach (query_buf[k]) send_byte(query_buf[k], k == query_buf.size() - 1);
        query_buf.delete();
    endtask

    task automatic add_text(string s);
        foreach (s[k]) query_buf.push_back(s[k]);
    endtask

    // wait for all predicted results, then for a possible silent byte to settle
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_capacity(logic [LEN_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_token();
        int    kind;
        int    n;
        string punct;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: begin
                n = $urandom_range(1, 5);
                repeat (n) begin
                    if ($urandom_range(0, 7) == 0) query_buf.push_back("_");
                    else query_buf.push_back(BYTE_W'(($urandom_range(0, 1) ? "a" : "A")
                                                     + $urandom_range(0, 25)));
                end
            end
            3: begin
                n = $urandom_range(1, 3);
                repeat (n) query_buf.push_back(BYTE_W'("0" + $urandom_range(0, 9)));
                if ($urandom_range(0, 1)) begin
                    query_buf.push_back(CH_DOT);
                    n = $urandom_range(0, 2);
                    repeat (n) query_buf.push_back(BYTE_W'("0" + $urandom_range(0, 9)));
                    if ($urandom_range(0, 3) == 0) query_buf.push_back(CH_DOT);
                end
            end
            4: begin
                query_buf.push_back(CH_QUOTE);
                n = $urandom_range(0, 4);
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0: begin
                            query_buf.push_back(CH_QUOTE);
                            query_buf.push_back(CH_QUOTE);
                        end
                        1: query_buf.push_back(CH_SPACE);
                        default: query_buf.push_back(BYTE_W'("a" + $urandom_range(0, 25)));
                    endcase
                end
                // now and then the string stays open
                if ($urandom_range(0, 7) != 0) query_buf.push_back(CH_QUOTE);
            end
            5, 6: begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    if ($urandom_range(0, 1)) query_buf.push_back(CH_SPACE);
                    else query_buf.push_back(BYTE_W'($urandom_range(9, 13)));
                end
            end
            7: begin
                // one punctuation character
                punct = "(),=*<>;.";
                query_buf.push_back(punct[$urandom_range(0, 8)]);
            end
            default: query_buf.push_back(BYTE_W'($urandom_range(0, 255)));
        endcase
    endtask

    // run limit
    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int phase;
        int n_tokens;
        int phase_end;
        bytes_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed queries at the reset capacity
        add_text("\t A'b''c' 1.5.x ");
        query_buf.push_back(8'h00);
        query_buf.push_back(8'hFF);
        send_query();
        add_text("9");
        send_query();
        add_text("'a'");
        send_query();
        add_text("'x");
        send_query();
        add_text("Z ");
        send_query();
        drain();

        // random queries over several capacity settings
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_capacity(16'd0);
                1: write_capacity(16'hFFFF);
                2: write_capacity(16'd1);
                3: write_capacity(LEN_W'($urandom_range(2, 6)));
                4: write_capacity(LEN_W'($urandom_range(3, 15)));
                default: write_capacity(LEN_W'($urandom_range(0, 16'hFFFF)));
            endcase
            calm = (phase == 4);
            phase_end = bytes_sent + 13;
            while (bytes_sent < phase_end) begin
                n_tokens = $urandom_range(1, 6);
                if ($urandom_range(0, 3) == 0) query_buf.push_back(CH_SPACE);
                repeat (n_tokens) add_token();
                send_query();
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
